/* hdl/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Each macro expects signals named aclk and aresetn in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/pic_pkg.sv */
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, register map, command and error codes, and the fixed
// priority level table of the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

    // Number of status / enable / free-run words
    localparam int NUM_SETS = 5;
    localparam int SET_W    = $clog2(NUM_SETS);

    typedef logic [NUM_SETS-1:0][31:0] word_array_t;
    typedef logic [SET_W-1:0]          set_idx_t;

    // Commands
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_RAISE     = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_FR_ON     = 3'd4;
    localparam logic [2:0] CMD_FR_OFF    = 3'd5;
    localparam logic [2:0] CMD_CPU_RESET = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_BAD_ADDR = 2'd1;
    localparam logic [1:0] ERR_RSVD     = 2'd2;
    localparam logic [1:0] ERR_TEST     = 2'd3;

    // Register map (word offsets)
    localparam logic [5:0] OFF_STATUS6 = 6'd5;
    localparam logic [5:0] OFF_ENABLE0 = 6'd6;
    localparam logic [5:0] OFF_CONTROL = 6'd11;

    // Control word fields
    localparam logic [31:0] CTL_TEST  = 32'h0003_0000;
    localparam logic [31:0] CTL_RSVD  = 32'hFFF8_0000;
    localparam int          CTL_GLOBAL_BIT = 18;

    // Priority table: two status terms per level, each a word index and a bit mask
    localparam logic [2:0] TERM_SET [0:15][0:1] = '{
        '{3'd0, 3'd0}, '{3'd4, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0},
        '{3'd0, 3'd0}, '{3'd1, 3'd0}, '{3'd3, 3'd4}, '{3'd3, 3'd0},
        '{3'd2, 3'd4}, '{3'd2, 3'd0}, '{3'd1, 3'd0}, '{3'd1, 3'd0},
        '{3'd1, 3'd0}, '{3'd4, 3'd0}, '{3'd4, 3'd0}, '{3'd4, 3'd0}
    };

    localparam logic [31:0] TERM_MASK [0:15][0:1] = '{
        '{32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0081, 32'h0000_0000},
        '{32'h0800_0000, 32'h0000_0000},
        '{32'h0002_0000, 32'h0000_0000},
        '{32'h0004_0000, 32'h0000_0000},
        '{32'h0000_0020, 32'h0000_0000},
        '{32'h0000_0003, 32'h0000_0060},
        '{32'h000F_0000, 32'h0000_0000},
        '{32'h0000_0003, 32'h0000_3000},
        '{32'h000F_0000, 32'h0000_0000},
        '{32'h0020_0000, 32'h0000_0000},
        '{32'h8000_0000, 32'h0000_0000},
        '{32'h0000_000C, 32'h0000_0000},
        '{32'h2000_0000, 32'h0000_0000},
        '{32'h4000_0000, 32'h0000_0000},
        '{32'h0300_0000, 32'h0000_0000}
    };

    // Enable bits that may not be written for a given enable word
    function automatic logic [31:0] enable_reserved(input set_idx_t idx);
        logic [31:0] mask;
        mask = 32'h0000_0000;
        if (int'(idx) == 0) begin
            mask = 32'h0000_001F;
        end else if (int'(idx) == 1) begin
            mask = 32'h0000_0003;
        end
        return mask;
    endfunction

endpackage

/* hdl/pic_prio_enc.sv */
// ----------------------------------------------------------------------------
// pic_prio_enc
// Fixed 15-level priority encoder over the status words, masked by the
// priority mask. Level 0 means nothing pending.
// ----------------------------------------------------------------------------
module pic_prio_enc (
    input  pic_pkg::word_array_t status_words,
    input  logic [15:0]          priority_mask,
    output logic [3:0]           level
);
    import pic_pkg::*;

    logic [15:1] hits;

    // Evaluate every level's status terms in parallel
    always_comb begin
        for (int l = 1; l < 16; l++) begin
            hits[l] = 1'b0;
            for (int k = 0; k < 2; k++) begin
                if (TERM_MASK[l][k] != 32'h0 && int'(TERM_SET[l][k]) < NUM_SETS) begin
                    if ((status_words[TERM_SET[l][k][SET_W-1:0]] & TERM_MASK[l][k]) != 32'h0)
                    begin
                        hits[l] = 1'b1;
                    end
                end
            end
            hits[l] = hits[l] & priority_mask[l];
        end
    end

    // Pick the highest pending level
    always_comb begin
        level = 4'd0;
        for (int l = 1; l < 16; l++) begin
            if (hits[l]) begin
                level = 4'(l);
            end
        end
    end

endmodule

/* hdl/priority_interrupt_controller_top.sv */
// Latency: a result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while m_ready stays high; the output register accepts a new word
// in the same cycle that the held result is taken.
// Reset: synchronous active-low aresetn clears all status, enable and free-run
// words, the priority mask, the global enable and the output valid flag.
// ----------------------------------------------------------------------------
// priority_interrupt_controller_top
// Interrupt controller with status, enable and free-run words, a control
// word, and a fixed priority encoder. Each accepted word updates the state
// and yields one result word with the interrupt lines after the update.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [5:0]  s_word_offset,
    input  logic [2:0]  s_source_set,
    input  logic [31:0] s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_low,
    output logic        m_irq_high,
    output logic [3:0]  m_vector_level,
    output logic [1:0]  m_error
);
    import pic_pkg::*;

    // State
    word_array_t status_reg, status_next;
    word_array_t enable_reg, enable_next;
    word_array_t free_run_reg, free_run_next;
    logic [15:0] pmask_reg, pmask_next;
    logic        genable_reg, genable_next;

    // Output register
    logic        m_valid_reg;
    logic [31:0] m_read_data_reg;
    logic        m_irq_low_reg;
    logic        m_irq_high_reg;
    logic [3:0]  m_vector_level_reg;
    logic [1:0]  m_error_reg;

    logic        s_accept;
    logic        is_bus;
    logic        off_status;
    logic        off_enable;
    logic        set_ok;
    logic [5:0]  enable_off;
    set_idx_t    sel_idx;
    logic [31:0] st_sel, en_sel, fr_sel;
    logic [31:0] st_new, en_new, fr_new;
    logic        wr_st, wr_en, wr_fr;
    logic [31:0] rd_word;
    logic        rd_status6;
    logic [1:0]  err;
    logic [3:0]  level_next;
    logic        irq_low_next;
    logic        irq_high_next;
    logic [31:0] read_data_next;

    // Output register frees up when empty or when its word is taken
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Decode address regions and pick the one word this item touches
    assign is_bus     = (s_cmd == CMD_READ) || (s_cmd == CMD_WRITE);
    assign enable_off = s_word_offset - OFF_ENABLE0;
    assign off_status = int'(s_word_offset) < NUM_SETS;
    assign off_enable = (s_word_offset >= OFF_ENABLE0) &&
                        (int'(s_word_offset) < int'(OFF_ENABLE0) + NUM_SETS);
    assign set_ok     = int'(s_source_set) < NUM_SETS;

    always_comb begin
        if (!is_bus) begin
            sel_idx = s_source_set[SET_W-1:0];
        end else if (off_status) begin
            sel_idx = s_word_offset[SET_W-1:0];
        end else begin
            sel_idx = enable_off[SET_W-1:0];
        end
    end

    assign st_sel = status_reg[sel_idx];
    assign en_sel = enable_reg[sel_idx];
    assign fr_sel = free_run_reg[sel_idx];

    // Execute the command against the selected word
    always_comb begin
        st_new       = st_sel;
        en_new       = en_sel;
        fr_new       = fr_sel;
        wr_st        = 1'b0;
        wr_en        = 1'b0;
        wr_fr        = 1'b0;
        pmask_next   = pmask_reg;
        genable_next = genable_reg;
        rd_word      = 32'h0;
        rd_status6   = 1'b0;
        err          = ERR_OK;
        unique case (s_cmd)
            CMD_READ: begin
                priority if (off_status) begin
                    rd_word = st_sel;
                end else if (s_word_offset == OFF_STATUS6) begin
                    rd_status6 = 1'b1;
                end else if (off_enable) begin
                    rd_word = en_sel;
                end else if (s_word_offset == OFF_CONTROL) begin
                    rd_word = {13'h0, genable_reg, 2'b00, pmask_reg};
                end else begin
                    err = ERR_BAD_ADDR;
                end
            end
            CMD_WRITE: begin
                priority if (off_status) begin
                    st_new = (st_sel & ~s_data) | fr_sel;
                    wr_st  = 1'b1;
                end else if (off_enable) begin
                    if ((s_data & enable_reserved(sel_idx)) != 32'h0) begin
                        err = ERR_RSVD;
                    end else begin
                        en_new = s_data;
                        wr_en  = 1'b1;
                    end
                end else if (s_word_offset == OFF_CONTROL) begin
                    priority if ((s_data & CTL_TEST) != 32'h0) begin
                        err = ERR_TEST;
                    end else if ((s_data & CTL_RSVD) != 32'h0) begin
                        err = ERR_RSVD;
                    end else begin
                        genable_next = s_data[CTL_GLOBAL_BIT];
                        pmask_next   = s_data[15:0];
                    end
                end else begin
                    err = ERR_BAD_ADDR;
                end
            end
            CMD_RAISE, CMD_CLEAR, CMD_FR_ON, CMD_FR_OFF: begin
                if (!set_ok) begin
                    err = ERR_BAD_ADDR;
                end else if (s_cmd == CMD_RAISE) begin
                    st_new = st_sel | s_data;
                    wr_st  = 1'b1;
                end else if (s_cmd == CMD_CLEAR) begin
                    st_new = (st_sel & ~s_data) | fr_sel;
                    wr_st  = 1'b1;
                end else if (s_cmd == CMD_FR_ON) begin
                    fr_new = fr_sel | s_data;
                    st_new = st_sel | s_data;
                    wr_fr  = 1'b1;
                    wr_st  = 1'b1;
                end else begin
                    fr_new = fr_sel & ~s_data;
                    wr_fr  = 1'b1;
                end
            end
            CMD_CPU_RESET: begin
                genable_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Merge the updated word back into the arrays
    always_comb begin
        for (int i = 0; i < NUM_SETS; i++) begin
            status_next[i]   = (wr_st && sel_idx == SET_W'(i)) ? st_new : status_reg[i];
            enable_next[i]   = (wr_en && sel_idx == SET_W'(i)) ? en_new : enable_reg[i];
            free_run_next[i] = (wr_fr && sel_idx == SET_W'(i)) ? fr_new : free_run_reg[i];
        end
    end

    // Interrupt lines from the updated state
    pic_prio_enc u_prio_enc (
        .status_words  (status_next),
        .priority_mask (pmask_next),
        .level         (level_next)
    );

    always_comb begin
        logic [31:0] pending;
        pending = 32'h0;
        for (int i = 0; i < NUM_SETS; i++) begin
            pending = pending | (status_next[i] & enable_next[i]);
        end
        irq_low_next = genable_next && (pending != 32'h0);
    end

    assign irq_high_next  = genable_next && (level_next != 4'd0);
    assign read_data_next = rd_status6 ?
                            {irq_high_next, irq_low_next, 24'h0, level_next, 2'b00} : rd_word;

    // Control state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg   <= '0;
            enable_reg   <= '0;
            free_run_reg <= '0;
            pmask_reg    <= 16'h0;
            genable_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                status_reg   <= status_next;
                enable_reg   <= enable_next;
                free_run_reg <= free_run_next;
                pmask_reg    <= pmask_next;
                genable_reg  <= genable_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_read_data_reg    <= read_data_next;
            m_irq_low_reg      <= irq_low_next;
            m_irq_high_reg     <= irq_high_next;
            m_vector_level_reg <= level_next;
            m_error_reg        <= err;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = m_read_data_reg;
    assign m_irq_low      = m_irq_low_reg;
    assign m_irq_high     = m_irq_high_reg;
    assign m_vector_level = m_vector_level_reg;
    assign m_error        = m_error_reg;

endmodule

/* hdl/pic_checker.sv */
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks on the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_cmd,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_irq_low,
    input logic        m_irq_high,
    input logic [3:0]  m_vector_level,
    input logic [1:0]  m_error
);
    import pic_pkg::*;

    logic cpu_reset_taken;
    logic quiet_result;

    // Flag a taken cpu reset word and a result word with both lines down
    assign cpu_reset_taken = s_valid && s_ready && (s_cmd == CMD_CPU_RESET);
    assign quiet_result    = m_valid && !m_irq_low && !m_irq_high && (m_error == ERR_OK);

    // Hold a stalled result word
    `ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_read_data))

    // High line implies a pending level
    `ASSERT_SAME(a_high_has_level, m_valid && m_irq_high, m_vector_level != 4'd0)

    // Failed items return no read data
    `ASSERT_SAME(a_err_no_data, m_valid && m_error != ERR_OK, m_read_data == 32'h0)

    // Cpu reset drops both lines in its result word
    `ASSERT_NEXT(a_cpu_reset_quiet, cpu_reset_taken, quiet_result)

endmodule

bind priority_interrupt_controller_top pic_checker u_pic_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_cmd          (s_cmd),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_data    (m_read_data),
    .m_irq_low      (m_irq_low),
    .m_irq_high     (m_irq_high),
    .m_vector_level (m_vector_level),
    .m_error        (m_error)
);
